@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the magic hash collision checker.
// No dependencies; include by bare file name in any module that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check prop on every rising edge while reset is released.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check prop on every rising edge, reset included.
`define ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ANY(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/mhcc_pkg.sv @@
// Shared types, constants and helpers for the magic hash collision checker.
// No dependencies; imported by every module of the block.
package mhcc_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int IDX_W         = 12;
    localparam int STAMP_W       = 16;
    localparam int CFG_W         = 4;
    localparam int WORD_W        = 64;
    localparam int HALF_W        = 32;

    localparam logic [CFG_W-1:0]   MAX_INDEX_BITS   = 4'd12;
    localparam logic [CFG_W-1:0]   INDEX_BITS_RESET = 4'd12;
    localparam logic [STAMP_W-1:0] GEN_RESET        = 16'd1;

    typedef struct packed {
        logic [WORD_W-1:0] magic;
        logic [WORD_W-1:0] occupancy;
        logic              first;
        logic              last;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] hash_index;
        logic             collided;
        logic             set_done;
        logic             magic_good;
    } t_out_item;

    // Hashed occupancy travelling down the pipe
    typedef struct packed {
        logic [IDX_W-1:0] hash_index;
        logic             first;
        logic             last;
    } t_probe;

    // Stamp table write request
    typedef struct packed {
        logic               valid;
        logic [SLOT_W-1:0]  slot;
        logic [STAMP_W-1:0] data;
    } t_stamp_wr;

    // Table entry for an index: index modulo the table depth
    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W:0] wide;
        wide = {1'b0, idx} % (IDX_W+1)'(TABLE_ENTRIES);
        return wide[SLOT_W-1:0];
    endfunction

endpackage

@@ rtl/magic_hash_collision_checker_top.sv @@
// Top level of the magic hash collision checker.
// Depends on mhcc_pkg, mhcc_fold, mhcc_stamp_ram, mhcc_stamp_check, assert_macros.svh.
//
// The block hashes each occupancy item with the candidate magic (two 32x32
// multiplies folded by XOR, top index_bits kept) and checks the index against
// a stamp table that records the generation that last used each entry. A
// first item opens a new set by advancing the 16-bit generation; the result
// item reports the index, whether it collided, and on the last item of a set
// whether the whole set was free of collisions. One item is taken per cycle
// while o_in_ready is high; the accepting edge loads the input register, and
// the item then passes the hash register, the stamp read and the result
// register in order; the whole pipe advances only while the result register
// is free or being taken, so a stalled output holds the input side. The stamp
// table is read in the cycle before the check and written back in the check
// cycle, with the previous write forwarded. After reset the table is cleared
// one entry a cycle, all 4096 entries, with o_in_ready held low; index_bits
// may be written then.
`include "assert_macros.svh"
module magic_hash_collision_checker_top import mhcc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration: index_bits
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    // input items
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    // result items
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data
);

    logic [CFG_W-1:0] r_index_bits;

    // pipe valids and payloads
    logic             r_a_valid;
    t_in_item         r_a_item;
    logic             r_b_valid;
    t_probe           r_b_probe;
    logic             r_c_valid;
    t_probe           r_c_probe;
    logic             r_out_valid;
    t_out_item        r_out_item;

    logic               en;
    logic               accept;
    logic               ram_busy;
    logic [IDX_W-1:0]   hash_index;
    logic [STAMP_W-1:0] rd_data;
    t_stamp_wr          wr;
    t_out_item          result;

    // advance the whole pipe whenever the result register can take a new item
    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en && !ram_busy;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits <= INDEX_BITS_RESET;
        end else if (i_cfg_we) begin
            r_index_bits <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_a_valid   <= accept;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid;
        end
    end

    // payloads follow their valids; hold everything while the output stalls
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_item             <= i_in_data;
            r_b_probe.hash_index <= hash_index;
            r_b_probe.first      <= r_a_item.first;
            r_b_probe.last       <= r_a_item.last;
            r_c_probe            <= r_b_probe;
            r_out_item           <= result;
        end
    end

    mhcc_fold u_fold (
        .i_magic      (r_a_item.magic),
        .i_occupancy  (r_a_item.occupancy),
        .i_index_bits (r_index_bits),
        .o_hash_index (hash_index)
    );

    // read for the item in the hash register, landing with it in the check stage
    mhcc_stamp_ram u_stamp_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (en),
        .i_rd_slot (slot_of(r_b_probe.hash_index)),
        .o_rd_data (rd_data),
        .i_wr      (wr),
        .o_busy    (ram_busy)
    );

    mhcc_stamp_check u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (r_c_valid),
        .i_probe   (r_c_probe),
        .i_rd_data (rd_data),
        .o_wr      (wr),
        .o_result  (result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    `ASSERT_RST(a_check_reaches_out, i_clk, i_rst_n, (en && r_c_valid) |=> o_out_valid, "checked item lost before the result register")
    `ASSERT_RST(a_pipe_empty_in_clear, i_clk, i_rst_n, ram_busy |-> (!r_a_valid && !r_b_valid && !r_c_valid), "item in flight during table clear")
    `ASSERT_RST(a_collision_not_good, i_clk, i_rst_n, (o_out_valid && o_out_data.collided) |-> !o_out_data.magic_good, "collided item reported a good magic")

endmodule

@@ rtl/mhcc_fold.sv @@
// Multiply-fold hash of one occupancy word down to a table index.
// Depends on mhcc_pkg; purely combinational, two 32x32 multipliers.
module mhcc_fold import mhcc_pkg::*; (
    input  logic [WORD_W-1:0] i_magic,
    input  logic [WORD_W-1:0] i_occupancy,
    input  logic [CFG_W-1:0]  i_index_bits,
    output logic [IDX_W-1:0]  o_hash_index
);

    logic [HALF_W-1:0] prod_lo;
    logic [HALF_W-1:0] prod_hi;
    logic [HALF_W-1:0] folded;
    logic [CFG_W-1:0]  bits_sat;
    logic [CFG_W-1:0]  shift;

    // low 32 bits of each product only
    assign prod_lo = i_occupancy[HALF_W-1:0] * i_magic[HALF_W-1:0];
    assign prod_hi = i_occupancy[WORD_W-1:HALF_W] * i_magic[WORD_W-1:HALF_W];
    assign folded  = prod_lo ^ prod_hi;

    // saturate at the table index width
    assign bits_sat = (i_index_bits > MAX_INDEX_BITS) ? MAX_INDEX_BITS : i_index_bits;
    assign shift    = MAX_INDEX_BITS - bits_sat;

    always_comb begin
        if (bits_sat == '0) begin
            o_hash_index = '0;
        end else begin
            o_hash_index = folded[HALF_W-1 -: IDX_W] >> shift;
        end
    end

endmodule

@@ rtl/mhcc_stamp_ram.sv @@
// Stamp table: one write port, one registered read port, clear sweep after reset.
// Depends on mhcc_pkg.
module mhcc_stamp_ram import mhcc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [SLOT_W-1:0]  i_rd_slot,
    output logic [STAMP_W-1:0] o_rd_data,
    input  t_stamp_wr          i_wr,
    output logic               o_busy
);

    logic [STAMP_W-1:0] r_mem [TABLE_ENTRIES];
    logic [STAMP_W-1:0] r_rd_data;
    logic [SLOT_W-1:0]  r_clr_slot;
    logic [SLOT_W-1:0]  n_clr_slot;
    logic               r_busy;
    logic               clr_last;

    assign clr_last   = (r_clr_slot == SLOT_W'(TABLE_ENTRIES - 1));
    assign n_clr_slot = r_clr_slot + SLOT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_slot <= '0;
        end else if (r_busy) begin
            r_clr_slot <= n_clr_slot;
            if (clr_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_slot] <= '0;
        end else if (i_wr.valid) begin
            r_mem[i_wr.slot] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_slot];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

@@ rtl/mhcc_stamp_check.sv @@
// Collision check stage: generation count, sticky collision flag, write forwarding.
// Depends on mhcc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mhcc_stamp_check import mhcc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_probe             i_probe,
    input  logic [STAMP_W-1:0] i_rd_data,
    output t_stamp_wr          o_wr,
    output t_out_item          o_result
);

    logic [STAMP_W-1:0] r_gen;
    logic               r_seen;
    logic               r_fwd_valid;
    logic [SLOT_W-1:0]  r_fwd_slot;
    logic [STAMP_W-1:0] r_fwd_data;

    logic [STAMP_W-1:0] gen_eff;
    logic [STAMP_W-1:0] stamp_cur;
    logic [SLOT_W-1:0]  slot;
    logic               hit;
    logic               seen_eff;
    logic               fire;

    assign fire    = i_en && i_valid;
    assign slot    = slot_of(i_probe.hash_index);
    assign gen_eff = i_probe.first ? (r_gen + STAMP_W'(1)) : r_gen;

    // the read was issued alongside the previous item's write: take that write
    assign stamp_cur = (r_fwd_valid && (r_fwd_slot == slot)) ? r_fwd_data : i_rd_data;
    assign hit       = (stamp_cur == gen_eff);
    assign seen_eff  = (i_probe.first ? 1'b0 : r_seen) | hit;

    always_comb begin
        o_wr.valid = fire && !hit;
        o_wr.slot  = slot;
        o_wr.data  = gen_eff;
    end

    always_comb begin
        o_result.hash_index = i_probe.hash_index;
        o_result.collided   = hit;
        o_result.set_done   = i_probe.last;
        o_result.magic_good = i_probe.last && !seen_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen       <= GEN_RESET;
            r_seen      <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else if (i_en) begin
            r_fwd_valid <= o_wr.valid;
            if (i_valid) begin
                r_gen  <= gen_eff;
                r_seen <= seen_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fwd_slot <= slot;
            r_fwd_data <= gen_eff;
        end
    end

    `ASSERT_RST(a_gen_only_on_first, i_clk, i_rst_n, !(fire && i_probe.first) |=> $stable(r_gen), "generation moved without a first item")
    `ASSERT_RST(a_hit_sets_seen, i_clk, i_rst_n, (fire && hit) |=> r_seen, "collision not recorded")
    `ASSERT_RST(a_miss_forwarded, i_clk, i_rst_n, (fire && !hit) |=> (r_fwd_valid && (r_fwd_slot == $past(slot))), "stamp write not held for forwarding")

endmodule
